### design/lc3x_pkg.sv
// Shared constants, codes and helper functions of the LC-3-like executor.
`default_nettype none
package lc3x_pkg;

  localparam int MEM_ADDR_BITS = 16;
  localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = $clog2(NUM_REGS);

  // Transaction kinds
  localparam logic [1:0] KIND_EXEC  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_MOD0 = 2'd2;

  // Opcodes
  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_MUL  = 4'd8;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_NEG  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  // Trap services
  localparam logic [2:0] TRAP_DIV   = 3'd0;
  localparam logic [2:0] TRAP_LOAD  = 3'd1;
  localparam logic [2:0] TRAP_PUTD  = 3'd2;
  localparam logic [2:0] TRAP_GETD  = 3'd3;
  localparam logic [2:0] TRAP_HALT  = 3'd4;
  localparam logic [2:0] TRAP_STORE = 3'd5;

  localparam logic [15:0] ASCII_ZERO = 16'd48;
  localparam logic [2:0]  FLAG_N = 3'b100;
  localparam logic [2:0]  FLAG_Z = 3'b010;
  localparam logic [2:0]  FLAG_P = 3'b001;

  function automatic logic [2:0] nzp(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'd0) f = FLAG_Z;
    else if (v[15]) f = FLAG_N;
    else f = FLAG_P;
    return f;
  endfunction

  function automatic logic [15:0] sext5(input logic [15:0] ins);
    return {{11{ins[4]}}, ins[4:0]};
  endfunction

  function automatic logic [15:0] sext6(input logic [15:0] ins);
    return {{10{ins[5]}}, ins[5:0]};
  endfunction

  function automatic logic [15:0] sext9(input logic [15:0] ins);
    return {{7{ins[8]}}, ins[8:0]};
  endfunction

  function automatic logic [15:0] sext11(input logic [15:0] ins);
    return {{5{ins[10]}}, ins[10:0]};
  endfunction

endpackage
`default_nettype wire

### design/lc3x_if.sv
// Valid/ready channel interfaces for instruction and result transactions.
`default_nettype none
interface lc3x_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] instruction;
  logic [15:0] address;
  logic [15:0] write_data;
  logic [7:0]  console_char;

  modport source (output valid, kind, instruction, address, write_data, console_char,
                  input ready);
  modport sink (input valid, kind, instruction, address, write_data, console_char,
                output ready);
endinterface

interface lc3x_out_if;
  logic        valid;
  logic        ready;
  logic        char_valid;
  logic [7:0]  char_out;
  logic        halted;
  logic [1:0]  error_code;
  logic [15:0] read_data;

  modport source (output valid, char_valid, char_out, halted, error_code, read_data,
                  input ready);
  modport sink (input valid, char_valid, char_out, halted, error_code, read_data,
                output ready);
endinterface
`default_nettype wire

### design/lc3x_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module lc3x_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write or read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

### design/lc3_like_instruction_executor.sv
// Top level: sequenced LC-3-like instruction executor with word memory.
`default_nettype none
// One transaction in, one result out. A transaction is decoded in the cycle after it is
// accepted; register and branch instructions finish there. Memory reads go through the
// single RAM port, whose read data is registered: LD, LDR, STI and memory reads pass through
// S_WAIT1, LDI through S_WAIT1 and S_WAIT2. MUL, MOD and the divide trap run 16 steps on
// one shared 17-bit adder/subtractor (shift-add or restoring division). The input is ready
// only while the sequencer is idle; a finished result sits in an output register, so the
// next transaction may be accepted while it waits.
module lc3_like_instruction_executor (
  input wire logic clk_i,
  input wire logic rst_ni,
  lc3x_in_if.sink  in_i,
  lc3x_out_if.source out_o
);
  import lc3x_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_WAIT1 = 7'b0000100,
    S_WAIT2 = 7'b0001000,
    S_ITER  = 7'b0010000,
    S_WB    = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]  kind_q;
  logic [15:0] ins_q, addr_q, wd_q;
  logic [7:0]  con_q;

  logic [15:0] rf_q [NUM_REGS];
  logic [15:0] pc_q, pc_d, trap_q, trap_d;
  logic [2:0]  flags_q, flags_d;
  logic        running_q, running_d;

  logic        pend_cv_q, pend_cv_d;
  logic [7:0]  pend_ch_q, pend_ch_d;
  logic [1:0]  pend_err_q, pend_err_d;

  logic [15:0] opa_q, opa_d, opb_q, opb_d;
  logic [16:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        is_div_q, is_div_d, rem_mode_q, rem_mode_d;
  logic [REG_IDX_W-1:0] dst_q, dst_d;

  logic                 rf_we;
  logic [REG_IDX_W-1:0] rf_wa;
  logic [15:0]          rf_wd;

  logic                     ram_we, ram_re;
  logic [MEM_ADDR_BITS-1:0] ram_addr;
  logic [15:0]              ram_wdata, ram_rdata;

  logic        out_valid_q;
  logic        out_cv_q, out_halt_q;
  logic [7:0]  out_ch_q;
  logic [1:0]  out_err_q;
  logic [15:0] out_rd_q;
  logic        out_load;

  // Decode fields
  logic [3:0]           op;
  logic [REG_IDX_W-1:0] dr, s1, s2, tr;
  logic [2:0]           tcode;
  logic [15:0]          r_dr, r_s1, r_s2, r_tr, op2, pc_off9;
  assign op      = ins_q[15:12];
  assign dr      = ins_q[11:9];
  assign s1      = ins_q[8:6];
  assign s2      = ins_q[2:0];
  assign tr      = ins_q[7:5];
  assign tcode   = ins_q[2:0];
  assign r_dr    = rf_q[dr];
  assign r_s1    = rf_q[s1];
  assign r_s2    = rf_q[s2];
  assign r_tr    = rf_q[tr];
  assign op2     = ins_q[5] ? sext5(ins_q) : r_s2;
  assign pc_off9 = pc_q + sext9(ins_q);

  // Shared adder/subtractor for multiply and divide steps
  logic [16:0] rem_sh, add_a, add_b, add_s;
  assign rem_sh = {acc_q[15:0], opa_q[15]};
  assign add_a  = is_div_q ? rem_sh : {1'b0, acc_q[15:0]};
  assign add_b  = {1'b0, (is_div_q ? opb_q : opa_q)};
  assign add_s  = is_div_q ? (add_a - add_b) : (add_a + add_b);

  logic [15:0] iter_res;
  assign iter_res = is_div_q ? (rem_mode_q ? acc_q[15:0] : opa_q) : acc_q[15:0];

  assign in_i.ready = (state_q == S_IDLE);
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  // Sequencer and datapath control
  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    trap_d     = trap_q;
    flags_d    = flags_q;
    running_d  = running_q;
    pend_cv_d  = pend_cv_q;
    pend_ch_d  = pend_ch_q;
    pend_err_d = pend_err_q;
    opa_d      = opa_q;
    opb_d      = opb_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    is_div_d   = is_div_q;
    rem_mode_d = rem_mode_q;
    dst_d      = dst_q;
    rf_we      = 1'b0;
    rf_wa      = dr;
    rf_wd      = 16'd0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = addr_q[MEM_ADDR_BITS-1:0];
    ram_wdata  = r_dr;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        pend_cv_d  = 1'b0;
        pend_ch_d  = 8'd0;
        pend_err_d = ERR_NONE;
        state_d    = S_FIN;
        priority if (kind_q == KIND_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = wd_q;
        end else if (kind_q == KIND_READ) begin
          ram_re  = 1'b1;
          state_d = S_WAIT1;
        end else if (kind_q == KIND_EXEC && running_q) begin
          unique case (op)
            OP_BR: if ((flags_q & ins_q[11:9]) != 3'd0) pc_d = pc_off9;
            OP_ADD: begin
              rf_we = 1'b1; rf_wd = r_s1 + op2; flags_d = nzp(r_s1 + op2);
            end
            OP_LD, OP_LDI: begin
              ram_re = 1'b1; ram_addr = pc_off9[MEM_ADDR_BITS-1:0]; state_d = S_WAIT1;
            end
            OP_STI: begin
              ram_re = 1'b1; ram_addr = pc_off9[MEM_ADDR_BITS-1:0]; state_d = S_WAIT1;
            end
            OP_ST: begin
              ram_we = 1'b1; ram_addr = pc_off9[MEM_ADDR_BITS-1:0];
            end
            OP_JSR: pc_d = ins_q[11] ? (pc_q + sext11(ins_q)) : r_s1;
            OP_AND: begin
              rf_we = 1'b1; rf_wd = r_s1 & op2; flags_d = nzp(r_s1 & op2);
            end
            OP_LDR: begin
              ram_re   = 1'b1;
              ram_addr = MEM_ADDR_BITS'(r_s1 + sext6(ins_q));
              state_d  = S_WAIT1;
            end
            OP_STR: begin
              ram_we = 1'b1; ram_addr = MEM_ADDR_BITS'(r_s1 + sext6(ins_q));
            end
            OP_MUL: begin
              dst_d = dr; opa_d = r_s1; opb_d = r_s2; acc_d = 17'd0; cnt_d = 4'd0;
              is_div_d = ins_q[5]; rem_mode_d = 1'b1;
              if (ins_q[5] && r_s2 == 16'd0) begin
                running_d  = 1'b0;
                pend_err_d = ERR_MOD0;
                flags_d    = nzp(r_dr);
              end else begin
                state_d = S_ITER;
              end
            end
            OP_NOT: begin
              rf_we = 1'b1; rf_wd = ~r_s1; flags_d = nzp(~r_s1);
            end
            OP_JMP: pc_d = r_s1;
            OP_NEG: begin
              rf_we = 1'b1; rf_wd = 16'd0 - r_dr; flags_d = nzp(16'd0 - r_dr);
            end
            OP_LEA: begin
              rf_we = 1'b1; rf_wd = pc_off9; flags_d = nzp(pc_off9);
            end
            OP_TRAP: begin
              rf_wa = tr;
              unique case (tcode)
                TRAP_DIV: begin
                  dst_d = tr; opa_d = r_tr; opb_d = trap_q; acc_d = 17'd0; cnt_d = 4'd0;
                  is_div_d = 1'b1; rem_mode_d = 1'b0;
                  if (trap_q == 16'd0) begin
                    running_d  = 1'b0;
                    pend_err_d = ERR_DIV0;
                  end else begin
                    state_d = S_ITER;
                  end
                end
                TRAP_LOAD: trap_d = r_tr;
                TRAP_PUTD: begin
                  pend_cv_d = 1'b1;
                  pend_ch_d = 8'(trap_q + ASCII_ZERO);
                end
                TRAP_GETD: trap_d = {8'd0, con_q} - ASCII_ZERO;
                TRAP_HALT: running_d = 1'b0;
                TRAP_STORE: begin
                  rf_we = 1'b1; rf_wd = trap_q;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end else begin
          // halted execute or unused kind: report only
        end
      end
      S_WAIT1: begin
        state_d = S_FIN;
        if (kind_q == KIND_EXEC) begin
          unique case (op)
            OP_LDI: begin
              ram_re = 1'b1; ram_addr = ram_rdata[MEM_ADDR_BITS-1:0]; state_d = S_WAIT2;
            end
            OP_STI: begin
              ram_we = 1'b1; ram_addr = ram_rdata[MEM_ADDR_BITS-1:0];
            end
            default: begin
              rf_we = 1'b1; rf_wd = ram_rdata; flags_d = nzp(ram_rdata);
            end
          endcase
        end
      end
      S_WAIT2: begin
        rf_we   = 1'b1;
        rf_wd   = ram_rdata;
        flags_d = nzp(ram_rdata);
        state_d = S_FIN;
      end
      S_ITER: begin
        cnt_d = cnt_q + 4'd1;
        if (is_div_q) begin
          if (!add_s[16]) begin
            acc_d = add_s;
            opa_d = {opa_q[14:0], 1'b1};
          end else begin
            acc_d = rem_sh;
            opa_d = {opa_q[14:0], 1'b0};
          end
        end else begin
          if (opb_q[0]) acc_d = add_s;
          opa_d = {opa_q[14:0], 1'b0};
          opb_d = {1'b0, opb_q[15:1]};
        end
        if (cnt_q == 4'd15) state_d = S_WB;
      end
      S_WB: begin
        rf_we   = 1'b1;
        rf_wa   = dst_q;
        rf_wd   = iter_res;
        flags_d = nzp(iter_res);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.kind;
      ins_q  <= in_i.instruction;
      addr_q <= in_i.address;
      wd_q   <= in_i.write_data;
      con_q  <= in_i.console_char;
    end
  end

  // Sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= 16'd0;
      trap_q    <= 16'd0;
      flags_q   <= FLAG_Z;
      running_q <= 1'b1;
      for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= 16'd0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      trap_q    <= trap_d;
      flags_q   <= flags_d;
      running_q <= running_d;
      if (rf_we) rf_q[rf_wa] <= rf_wd;
    end
  end

  // Iteration and pending-result payload
  always_ff @(posedge clk_i) begin
    pend_cv_q  <= pend_cv_d;
    pend_ch_q  <= pend_ch_d;
    pend_err_q <= pend_err_d;
    opa_q      <= opa_d;
    opb_q      <= opb_d;
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    is_div_q   <= is_div_d;
    rem_mode_q <= rem_mode_d;
    dst_q      <= dst_d;
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cv_q   <= pend_cv_q;
      out_ch_q   <= pend_ch_q;
      out_halt_q <= !running_q;
      out_err_q  <= pend_err_q;
      out_rd_q   <= (kind_q == KIND_READ) ? ram_rdata : 16'd0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.char_valid = out_cv_q;
  assign out_o.char_out   = out_ch_q;
  assign out_o.halted     = out_halt_q;
  assign out_o.error_code = out_err_q;
  assign out_o.read_data  = out_rd_q;

  lc3x_ram #(
    .Width(16),
    .Depth(MEM_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Checks
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q != ERR_NONE) |-> out_halt_q) else $error("error without halt");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_EXEC)) else $error("accept not decoded");
  a_char_noerr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_cv_q) |-> (out_err_q == ERR_NONE)) else $error("char with error");
  a_iter_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (cnt_q == 4'd0)) else $error("iteration count off");

endmodule
`default_nettype wire
